### rtl/tlvep_pkg.sv
`timescale 1ns / 1ps

package tlvep_pkg;

  localparam int unsigned MAX_IMAGE_BYTES_DEF = 2048;
  localparam int unsigned HEADER_BYTES        = 11;
  localparam int unsigned SIG_BYTES           = 7;

  localparam logic [7:0] PART_TAG_RST   = 8'h22;
  localparam logic [7:0] SERIAL_TAG_RST = 8'h23;
  localparam logic [7:0] FILLER_TYPE    = 8'hFF;

  // header byte positions
  localparam logic [3:0] HPOS_SIG_END = 4'd7;
  localparam logic [3:0] HPOS_LEN_HI  = 4'd9;

  localparam logic CFG_PART_TAG   = 1'b0;
  localparam logic CFG_SERIAL_TAG = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_TYPE   = 3'd2,
    PH_LEN    = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_OK      = 3'd1,
    ST_BADSIG  = 3'd2,
    ST_TOOBIG  = 3'd3,
    ST_OVERRUN = 3'd4
  } status_t;

  typedef struct packed {
    logic       capture_valid;
    logic       which_field;
    logic       field_begin;
    logic [7:0] char_index;
    logic [7:0] char_value;
    status_t    status;
  } result_t;

  // "TlvInfo"
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (pos)
      3'd0:    b = 8'h54;
      3'd1:    b = 8'h6C;
      3'd2:    b = 8'h76;
      3'd3:    b = 8'h49;
      3'd4:    b = 8'h6E;
      3'd5:    b = 8'h66;
      3'd6:    b = 8'h6F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/tlvep_core.sv
`timescale 1ns / 1ps

module tlvep_core #(
  parameter int unsigned MAX_IMAGE_BYTES = tlvep_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                image_start,
  input  logic [7:0]          part_tag,
  input  logic [7:0]          serial_tag,
  output tlvep_pkg::result_t  res
);
  import tlvep_pkg::*;

  localparam int unsigned CW = $clog2(MAX_IMAGE_BYTES);
  localparam logic [15:0] LEN_LIMIT = 16'(MAX_IMAGE_BYTES - HEADER_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hpos_r, hpos_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic [7:0]  etype_r, etype_nxt;
  logic [7:0]  vleft_r, vleft_nxt;
  logic [7:0]  vidx_r, vidx_nxt;
  logic        cap_r, cap_nxt;
  logic        fsel_r, fsel_nxt;

  phase_t      cur_phase;
  logic [3:0]  cur_hpos;
  logic [CW-1:0] bc_inc;
  logic        at_end;
  logic [15:0] tlen_full;
  logic        len_over;
  logic        is_part, is_serial;
  logic [7:0]  vleft_dec;

  assign cur_phase = image_start ? PH_HEADER : phase_r;
  assign cur_hpos  = image_start ? 4'd0 : hpos_r;
  assign bc_inc    = bc_r + 1'b1;
  assign at_end    = {{(16-CW){1'b0}}, bc_inc} >= tlen_r;
  assign tlen_full = tlen_r | {8'h00, data_byte};
  assign len_over  = ({{(17-CW){1'b0}}, bc_inc} + {9'd0, data_byte}) > {1'b0, tlen_r};
  assign is_part   = etype_r == part_tag;
  assign is_serial = etype_r == serial_tag;
  assign vleft_dec = vleft_r - 1'b1;

  // next state
  always_comb begin
    phase_nxt = cur_phase;
    hpos_nxt  = cur_hpos;
    tlen_nxt  = tlen_r;
    bc_nxt    = bc_r;
    etype_nxt = etype_r;
    vleft_nxt = vleft_r;
    vidx_nxt  = vidx_r;
    cap_nxt   = image_start ? 1'b0 : cap_r;
    fsel_nxt  = image_start ? 1'b0 : fsel_r;
    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_hpos < HPOS_SIG_END) begin
          if (data_byte != sig_byte(cur_hpos[2:0])) begin
            phase_nxt = PH_IDLE;
          end else begin
            hpos_nxt = cur_hpos + 1'b1;
          end
        end else if (cur_hpos < HPOS_LEN_HI) begin
          hpos_nxt = cur_hpos + 1'b1;
        end else if (cur_hpos == HPOS_LEN_HI) begin
          tlen_nxt = {data_byte, 8'h00};
          hpos_nxt = cur_hpos + 1'b1;
        end else begin
          tlen_nxt = tlen_full;
          bc_nxt   = '0;
          if (tlen_full > LEN_LIMIT || tlen_full == 16'd0) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        bc_nxt    = bc_inc;
        etype_nxt = data_byte;
        if (at_end) begin
          phase_nxt = PH_IDLE;
        end else if (data_byte != FILLER_TYPE) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        bc_nxt = bc_inc;
        if (len_over) begin
          phase_nxt = PH_IDLE;
        end else begin
          vidx_nxt  = 8'd0;
          vleft_nxt = data_byte;
          cap_nxt   = (is_part || is_serial) && data_byte != 8'd0;
          if (is_part) begin
            fsel_nxt = 1'b0;
          end else if (is_serial) begin
            fsel_nxt = 1'b1;
          end
          if (data_byte != 8'd0) begin
            phase_nxt = PH_VALUE;
          end else if (at_end) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      end
      PH_VALUE: begin
        bc_nxt    = bc_inc;
        vleft_nxt = vleft_dec;
        if (cap_r) begin
          if (data_byte == 8'd0) begin
            cap_nxt = 1'b0;
          end else begin
            vidx_nxt = vidx_r + 1'b1;
          end
        end
        if (vleft_dec == 8'd0) begin
          cap_nxt   = 1'b0;
          phase_nxt = at_end ? PH_IDLE : PH_TYPE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // result
  always_comb begin
    res = '{capture_valid: 1'b0, which_field: 1'b0, field_begin: 1'b0,
            char_index: 8'd0, char_value: 8'd0, status: ST_NONE};
    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_hpos < HPOS_SIG_END) begin
          if (data_byte != sig_byte(cur_hpos[2:0])) begin
            res.status = ST_BADSIG;
          end
        end else if (cur_hpos > HPOS_LEN_HI) begin
          if (tlen_full > LEN_LIMIT) begin
            res.status = ST_TOOBIG;
          end else if (tlen_full == 16'd0) begin
            res.status = ST_OK;
          end
        end
      end
      PH_TYPE: begin
        if (at_end) begin
          res.status = (data_byte == FILLER_TYPE) ? ST_OK : ST_OVERRUN;
        end
      end
      PH_LEN: begin
        if (len_over) begin
          res.status = ST_OVERRUN;
        end else begin
          res.field_begin = is_part || is_serial;
          res.which_field = !is_part && is_serial;
          if (data_byte == 8'd0 && at_end) begin
            res.status = ST_OK;
          end
        end
      end
      PH_VALUE: begin
        if (cap_r && data_byte != 8'd0) begin
          res.capture_valid = 1'b1;
          res.which_field   = fsel_r;
          res.char_index    = vidx_r;
          res.char_value    = data_byte;
        end
        if (vleft_dec == 8'd0 && at_end) begin
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hpos_r  <= '0;
      tlen_r  <= '0;
      bc_r    <= '0;
      etype_r <= '0;
      vleft_r <= '0;
      vidx_r  <= '0;
      cap_r   <= 1'b0;
      fsel_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      tlen_r  <= tlen_nxt;
      bc_r    <= bc_nxt;
      etype_r <= etype_nxt;
      vleft_r <= vleft_nxt;
      vidx_r  <= vidx_nxt;
      cap_r   <= cap_nxt;
      fsel_r  <= fsel_nxt;
    end
  end

endmodule

### rtl/tlv_eeprom_image_parser.sv
`timescale 1ns / 1ps

// TLV EEPROM image parser. Feed the image one byte per request, with
// in_tuser set on the first byte of each image. Every accepted byte yields
// exactly one result request. Throughput is one byte per cycle while
// out_tready keeps up: the byte is registered in the input register, the
// parser state machine updates as its result is taken into the output
// register, and out_tvalid rises once the result is there. While
// out_tready is low, one result waits in the output register and one byte
// waits in the input register, and then in_tready drops. The user must see
// that tags are changed through the cfg port only while no image byte is in
// flight; the block itself does not enforce it.

module tlv_eeprom_image_parser #(
  parameter int unsigned MAX_IMAGE_BYTES = tlvep_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] image_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] capture_valid, [1] field_begin,
                                  // [9:2] char_index, [17:10] char_value,
                                  // [20:18] status, [23:21] zero
  output logic        out_tuser,  // [0] which_field
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import tlvep_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    res;
  logic [7:0] part_tag_r, serial_tag_r;
  logic       adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  tlvep_core #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .data_byte  (s1_byte_r),
    .image_start(s1_start_r),
    .part_tag   (part_tag_r),
    .serial_tag (serial_tag_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      part_tag_r   <= PART_TAG_RST;
      serial_tag_r <= SERIAL_TAG_RST;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PART_TAG:   part_tag_r   <= cfg_wdata;
          CFG_SERIAL_TAG: serial_tag_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.which_field;
  assign out_tdata  = {3'b000, out_r.status, out_r.char_value, out_r.char_index,
                       out_r.field_begin, out_r.capture_valid};

endmodule
